// File: rtl/core/rlmf_pkg.sv
// Shared types and constants of the raster local minimum finder.
// No dependencies; the other files that use it refer to it by scoped names.
package rlmf_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_ROWS   = 1024;

    localparam int PIX_W      = 4;
    localparam int LINE_W     = 2 * PIX_W;           // {older, newer} per column
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int ROWPOS_W   = ROW_W + 1;           // runs up to image_rows+2 while flushing
    localparam int CR_W       = ROWPOS_W + 1;        // signed row of the decided pixel
    localparam int WCFG_W     = 8;
    localparam int RCFG_W     = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int RISK_W     = 21;
    localparam int LOW_W      = 18;
    localparam int WIN_N      = 9;
    localparam int WIN_CTR    = 4;

    localparam logic [WCFG_W-1:0]    WIDTH_RESET = 8'd100;
    localparam logic [RCFG_W-1:0]    ROWS_RESET  = 11'd100;
    localparam logic [WCFG_W-1:0]    WIDTH_MAX   = WCFG_W'(MAX_WIDTH);
    localparam logic [RCFG_W-1:0]    ROWS_MAX    = RCFG_W'(MAX_ROWS);
    localparam logic [RISK_W-1:0]    RISK_SAT    = '1;
    localparam logic [LOW_W-1:0]     LOW_SAT     = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 1'd1;

    // request codes
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [PIX_W-1:0] height_value;
    } in_word_t;

    typedef struct packed {
        logic              decided;
        logic              is_low_point;
        logic [COL_W-1:0]  pixel_column;
        logic [ROW_W-1:0]  pixel_row;
        logic [RISK_W-1:0] risk_total;
        logic [LOW_W-1:0]  low_count;
        logic              frame_done;
    } out_word_t;

endpackage

// File: rtl/core/rlmf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; a read during a write to the same address returns old data.
module rlmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/raster_local_minimum_finder.sv
// Top level of the raster 3x3 local minimum finder: position tracking, line RAM,
// window, comparisons and running sums. Depends on rlmf_pkg and rlmf_ram.
//
//  port group   dir   handshake            payload
//  s_*          in    s_valid / s_ready    s_data   (rlmf_pkg::in_word_t)
//  m_*          out   m_valid / m_ready    m_data   (rlmf_pkg::out_word_t)
//  cfg_*        in    cfg_wr_en            cfg_addr, cfg_wdata
//
// One word per cycle while the m side accepts; a taken word passes the stage 1 register, then the
// output register. Stage 0 reads the line RAM at the column; stage 1 shifts the window,
// writes the column back (forwarded when the next word reads the same column) and decides.
// aresetn is synchronous; the line RAM needs no clearing pass after reset.
// A stalled m side holds stage 1, and s_ready drops only when stage 1 cannot drain.
module raster_local_minimum_finder (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  rlmf_pkg::in_word_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output rlmf_pkg::out_word_t                  m_data,
    input  logic                                 cfg_wr_en,
    input  logic [rlmf_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [rlmf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int PW = rlmf_pkg::PIX_W;
    localparam int CW = rlmf_pkg::COL_W;
    localparam int RW = rlmf_pkg::ROW_W;
    localparam int PRW = rlmf_pkg::ROWPOS_W;
    localparam int CRW = rlmf_pkg::CR_W;
    localparam int WW = rlmf_pkg::WCFG_W;
    localparam int RCW = rlmf_pkg::RCFG_W;
    localparam int LW = rlmf_pkg::LINE_W;
    localparam int KW = rlmf_pkg::RISK_W;
    localparam int NW = rlmf_pkg::LOW_W;
    localparam int WN = rlmf_pkg::WIN_N;
    localparam int WC = rlmf_pkg::WIN_CTR;

    // configuration and stage 0 state
    logic [WW-1:0]  image_width_reg, image_width_next;
    logic [RCW-1:0] image_rows_reg, image_rows_next;
    logic [CW-1:0]  col_pos_reg, col_pos_next;
    logic [PRW-1:0] row_pos_reg, row_pos_next;
    logic           frame_done_reg, frame_done_next;

    // stage 1
    logic           s1_valid_reg, s1_valid_next;
    logic           s1_active_reg, s1_active_next;
    logic           s1_decided_reg, s1_decided_next;
    logic [PW-1:0]  s1_pix_reg, s1_pix_next;
    logic [CW-1:0]  s1_addr_reg, s1_addr_next;
    logic [WN-1:0]  s1_mask_reg, s1_mask_next;
    logic [CW-1:0]  s1_col_reg, s1_col_next;
    logic [RW-1:0]  s1_row_reg, s1_row_next;
    logic           s1_done_reg, s1_done_next;
    logic           s1_hit_reg, s1_hit_next;
    logic [LW-1:0]  fwd_data_reg, fwd_data_next;
    logic [PW-1:0]  win_reg [WN];
    logic [PW-1:0]  win_next [WN];
    logic [KW-1:0]  risk_reg, risk_next;
    logic [NW-1:0]  low_reg, low_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    rlmf_pkg::out_word_t m_data_reg, m_data_next;

    // stage 0 combinational
    logic [WW-1:0]  w_eff;
    logic [RCW-1:0] rows_eff;
    logic           s_fire, is_flush, in_image, active;
    logic           col_wrap;
    logic [CRW-1:0] cr;
    logic [WW-1:0]  cc;
    logic           decided, last_pix;
    logic           up_ok, down_ok, left_ok, right_ok;
    logic [WN-1:0]  mask;
    logic [PW-1:0]  pix;

    // stage 1 combinational
    logic           s1_adv;
    logic           ram_we, ram_re;
    logic [LW-1:0]  ram_rdata, line_word, ram_wdata;
    logic [PW-1:0]  win_shift [WN];
    logic [PW-1:0]  centre;
    logic           low_pt;
    logic [KW:0]    risk_sum;

    assign w_eff = (image_width_reg == '0) ? WW'(1) :
                   (image_width_reg > rlmf_pkg::WIDTH_MAX) ? rlmf_pkg::WIDTH_MAX :
                   image_width_reg;
    assign rows_eff = (image_rows_reg == '0) ? RCW'(1) :
                      (image_rows_reg > rlmf_pkg::ROWS_MAX) ? rlmf_pkg::ROWS_MAX :
                      image_rows_reg;

    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign s_fire  = s_valid && s_ready;

    assign is_flush = (s_data.req_type == rlmf_pkg::REQ_FLUSH);
    assign in_image = (RCW'(row_pos_reg) < rows_eff);
    assign active   = !frame_done_reg && !(is_flush && in_image);
    assign pix      = in_image ? s_data.height_value : '0;
    assign col_wrap = ({1'b0, col_pos_reg} + WW'(1)) >= w_eff;

    // decided pixel: one row and one column behind, or last column two rows up
    always_comb begin
        if (col_pos_reg != '0) begin
            cr = {1'b0, row_pos_reg} - CRW'(1);
            cc = {1'b0, col_pos_reg} - WW'(1);
        end else begin
            cr = {1'b0, row_pos_reg} - CRW'(2);
            cc = w_eff - WW'(1);
        end
    end

    assign decided  = active && !cr[CRW-1] && (cr[CRW-2:0] < rows_eff);
    assign last_pix = (cr[CRW-2:0] == rows_eff - RCW'(1)) && (cc == w_eff - WW'(1));
    assign up_ok    = (cr[CRW-2:0] != '0);
    assign down_ok  = ({1'b0, cr[CRW-2:0]} + CRW'(1)) < {1'b0, rows_eff};
    assign left_ok  = (cc != '0);
    assign right_ok = ({1'b0, cc} + (WW+1)'(1)) < {1'b0, w_eff};

    // mask of neighbours inside the image, same order as the window
    assign mask = {down_ok & right_ok, down_ok, down_ok & left_ok,
                   right_ok, 1'b0, left_ok,
                   up_ok & right_ok, up_ok, up_ok & left_ok};

    // line RAM: read at accept, write back from stage 1
    assign ram_re    = s_fire && active;
    assign ram_we    = s1_adv && s1_active_reg;
    assign line_word = s1_hit_reg ? fwd_data_reg : ram_rdata;
    assign ram_wdata = {line_word[PW-1:0], s1_pix_reg};

    rlmf_ram #(
        .WIDTH (LW),
        .DEPTH (rlmf_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (s1_addr_reg),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (col_pos_reg),
        .rd_data (ram_rdata)
    );

    always_comb begin
        win_shift[0] = win_reg[1];
        win_shift[1] = win_reg[2];
        win_shift[2] = line_word[LW-1:PW];
        win_shift[3] = win_reg[4];
        win_shift[4] = win_reg[5];
        win_shift[5] = line_word[PW-1:0];
        win_shift[6] = win_reg[7];
        win_shift[7] = win_reg[8];
        win_shift[8] = s1_pix_reg;
    end

    assign centre = win_shift[WC];

    always_comb begin
        low_pt = s1_decided_reg;
        for (int k = 0; k < WN; k++) begin
            if (s1_mask_reg[k] && (win_shift[k] <= centre)) begin
                low_pt = 1'b0;
            end
        end
    end

    assign risk_sum = {1'b0, risk_reg} + (KW+1)'(centre) + (KW+1)'(1);

    always_comb begin
        image_width_next = image_width_reg;
        image_rows_next  = image_rows_reg;
        col_pos_next     = col_pos_reg;
        row_pos_next     = row_pos_reg;
        frame_done_next  = frame_done_reg;
        s1_valid_next    = s1_valid_reg;
        s1_active_next   = s1_active_reg;
        s1_decided_next  = s1_decided_reg;
        s1_pix_next      = s1_pix_reg;
        s1_addr_next     = s1_addr_reg;
        s1_mask_next     = s1_mask_reg;
        s1_col_next      = s1_col_reg;
        s1_row_next      = s1_row_reg;
        s1_done_next     = s1_done_reg;
        s1_hit_next      = s1_hit_reg;
        fwd_data_next    = fwd_data_reg;
        risk_next        = risk_reg;
        low_next         = low_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        for (int k = 0; k < WN; k++) begin
            win_next[k] = win_reg[k];
        end

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        // stage 1 -> output register
        if (s1_adv) begin
            s1_valid_next = 1'b0;
            if (s1_active_reg) begin
                for (int k = 0; k < WN; k++) begin
                    win_next[k] = win_shift[k];
                end
                fwd_data_next = ram_wdata;
            end
            if (low_pt) begin
                risk_next = risk_sum[KW] ? rlmf_pkg::RISK_SAT : risk_sum[KW-1:0];
                if (low_reg != rlmf_pkg::LOW_SAT) begin
                    low_next = low_reg + NW'(1);
                end
            end
            m_valid_next              = 1'b1;
            m_data_next.decided       = s1_decided_reg;
            m_data_next.is_low_point  = low_pt;
            m_data_next.pixel_column  = s1_col_reg;
            m_data_next.pixel_row     = s1_row_reg;
            m_data_next.risk_total    = risk_next;
            m_data_next.low_count     = low_next;
            m_data_next.frame_done    = s1_done_reg;
        end

        // stage 0 -> stage 1
        if (s_fire) begin
            s1_valid_next   = 1'b1;
            s1_active_next  = active;
            s1_decided_next = decided;
            s1_pix_next     = pix;
            s1_addr_next    = col_pos_reg;
            s1_mask_next    = mask;
            s1_col_next     = decided ? cc[CW-1:0] : '0;
            s1_row_next     = decided ? cr[RW-1:0] : '0;
            // forward the word written back at this same edge
            s1_hit_next     = ram_we && (s1_addr_reg == col_pos_reg);
            if (active) begin
                if (col_wrap) begin
                    col_pos_next = '0;
                    row_pos_next = row_pos_reg + PRW'(1);
                end else begin
                    col_pos_next = col_pos_reg + CW'(1);
                end
                if (decided && last_pix) begin
                    frame_done_next = 1'b1;
                end
            end
            s1_done_next = frame_done_next;
        end

        // register write restarts the frame
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                rlmf_pkg::CFG_IMAGE_WIDTH: image_width_next = cfg_wdata[WW-1:0];
                rlmf_pkg::CFG_IMAGE_ROWS:  image_rows_next  = cfg_wdata[RCW-1:0];
                default: ;
            endcase
            col_pos_next    = '0;
            row_pos_next    = '0;
            frame_done_next = 1'b0;
            risk_next       = '0;
            low_next        = '0;
            for (int k = 0; k < WN; k++) begin
                win_next[k] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg <= rlmf_pkg::WIDTH_RESET;
            image_rows_reg  <= rlmf_pkg::ROWS_RESET;
            col_pos_reg     <= '0;
            row_pos_reg     <= '0;
            frame_done_reg  <= 1'b0;
            s1_valid_reg    <= 1'b0;
            risk_reg        <= '0;
            low_reg         <= '0;
            m_valid_reg     <= 1'b0;
            for (int k = 0; k < WN; k++) begin
                win_reg[k] <= '0;
            end
        end else begin
            image_width_reg <= image_width_next;
            image_rows_reg  <= image_rows_next;
            col_pos_reg     <= col_pos_next;
            row_pos_reg     <= row_pos_next;
            frame_done_reg  <= frame_done_next;
            s1_valid_reg    <= s1_valid_next;
            risk_reg        <= risk_next;
            low_reg         <= low_next;
            m_valid_reg     <= m_valid_next;
            for (int k = 0; k < WN; k++) begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        s1_active_reg  <= s1_active_next;
        s1_decided_reg <= s1_decided_next;
        s1_pix_reg     <= s1_pix_next;
        s1_addr_reg    <= s1_addr_next;
        s1_mask_reg    <= s1_mask_next;
        s1_col_reg     <= s1_col_next;
        s1_row_reg     <= s1_row_next;
        s1_done_reg    <= s1_done_next;
        s1_hit_reg     <= s1_hit_next;
        fwd_data_reg   <= fwd_data_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/core/rlmf_checker.sv
// Port-level checks on the raster local minimum finder, bound to the top level.
// Depends on rlmf_pkg and raster_local_minimum_finder.
module rlmf_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input rlmf_pkg::out_word_t             m_data
);

    // hold a stalled result word
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a word without a decision carries no pixel
    a_undecided: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.decided |->
            !m_data.is_low_point && m_data.pixel_column == '0 && m_data.pixel_row == '0)
        else $error("undecided word carries pixel fields");

    // every low point adds at least one to the risk sum
    a_risk_vs_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.risk_total >= rlmf_pkg::RISK_W'(m_data.low_count))
        else $error("risk total below low point count");

endmodule

bind raster_local_minimum_finder rlmf_checker u_rlmf_checker (.*);

// File: sim/tb_top.sv
// Self-checking bench for raster_local_minimum_finder: a queue-fed bursty driver,
// a stalling result sink and an in-bench model of the 3x3 low-point decision.
// Depends on rlmf_pkg and the RTL under rtl/core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {ACT_WORD, ACT_WRITE, ACT_HOLD} act_kind_t;

    typedef struct {
        act_kind_t                       kind;
        rlmf_pkg::in_word_t              word;
        logic [rlmf_pkg::CFG_IDX_W-1:0]  idx;
        logic [rlmf_pkg::CFG_DATA_W-1:0] val;
    } stim_act_t;

    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int STALL_LIMIT   = 3000;
    localparam int ITEM_BUDGET   = 1150;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    rlmf_pkg::in_word_t              s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    rlmf_pkg::out_word_t             m_data;
    logic                            cfg_wr_en = 1'b0;
    logic [rlmf_pkg::CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [rlmf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    stim_act_t           stim_q[$];
    rlmf_pkg::out_word_t decision_q[$];
    int        mismatches    = 0;
    int        words_queued  = 0;
    int        burst_left    = 0;
    int        gap_left      = 0;
    int        settle        = 0;
    int        rdy_cyc       = 0;
    int        rdy_hold      = 0;
    int        stall_run     = 0;

    // shadow of the block: line stores, window, position, sums, registers
    logic [rlmf_pkg::PIX_W-1:0]  old_line[rlmf_pkg::MAX_WIDTH];
    logic [rlmf_pkg::PIX_W-1:0]  new_line[rlmf_pkg::MAX_WIDTH];
    logic [rlmf_pkg::PIX_W-1:0]  win[rlmf_pkg::WIN_N];
    int                          next_col;
    int                          next_row;
    int                          risk_sum;
    int                          low_sum;
    logic                        frame_over;
    logic [rlmf_pkg::WCFG_W-1:0] width_reg;
    logic [rlmf_pkg::RCFG_W-1:0] rows_reg;

    raster_local_minimum_finder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int eff_width(int v);
        if (v == 0) return 1;
        if (v > rlmf_pkg::MAX_WIDTH) return rlmf_pkg::MAX_WIDTH;
        return v;
    endfunction

    function automatic int eff_rows(int v);
        if (v == 0) return 1;
        if (v > rlmf_pkg::MAX_ROWS) return rlmf_pkg::MAX_ROWS;
        return v;
    endfunction

    function automatic void restart_frame();
        for (int k = 0; k < rlmf_pkg::WIN_N; k++) win[k] = '0;
        next_col   = 0;
        next_row   = 0;
        risk_sum   = 0;
        low_sum    = 0;
        frame_over = 1'b0;
    endfunction

    function automatic void apply_setting(logic [rlmf_pkg::CFG_IDX_W-1:0] idx,
                                          logic [rlmf_pkg::CFG_DATA_W-1:0] val);
        if (idx == rlmf_pkg::CFG_IMAGE_WIDTH) width_reg = val[rlmf_pkg::WCFG_W-1:0];
        else rows_reg = val[rlmf_pkg::RCFG_W-1:0];
        restart_frame();
    endfunction

    // Shift the window by one word and decide the pixel one row and column behind, or the last column two rows up.
    function automatic rlmf_pkg::out_word_t decide_pixel(rlmf_pkg::in_word_t w);
        rlmf_pkg::out_word_t        r;
        int                         wd, rw, c, cr, cc, nr, nc, add;
        logic                       in_image, low;
        logic [rlmf_pkg::PIX_W-1:0] v, ctr;
        wd = eff_width(width_reg);
        rw = eff_rows(rows_reg);
        r = '0;
        in_image = next_row < rw;
        if (!frame_over && !(w.req_type == rlmf_pkg::REQ_FLUSH && in_image)) begin
            v = in_image ? w.height_value : '0;
            c = (next_col >= rlmf_pkg::MAX_WIDTH) ? 0 : next_col;
            for (int k = 0; k < 3; k++) begin
                win[3*k]   = win[3*k+1];
                win[3*k+1] = win[3*k+2];
            end
            win[2] = old_line[c];
            win[5] = new_line[c];
            win[8] = v;
            old_line[c] = new_line[c];
            new_line[c] = v;
            if (c >= 1) begin
                cr = next_row - 1;
                cc = c - 1;
            end else begin
                cr = next_row - 2;
                cc = wd - 1;
            end
            c++;
            if (c >= wd) begin
                c = 0;
                next_row++;
            end
            next_col = c;
            if (cr >= 0 && cr < rw) begin
                ctr = win[rlmf_pkg::WIN_CTR];
                low = 1'b1;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        nr = cr + dr;
                        nc = cc + dc;
                        // skip the centre and anything off the image
                        if ((dr != 0 || dc != 0) && nr >= 0 && nr < rw && nc >= 0 && nc < wd)
                            if (win[(dr+1)*3 + dc + 1] <= ctr) low = 1'b0;
                    end
                end
                if (low) begin
                    add = int'(ctr) + 1;
                    if (risk_sum > int'(rlmf_pkg::RISK_SAT) - add)
                        risk_sum = int'(rlmf_pkg::RISK_SAT);
                    else risk_sum += add;
                    if (low_sum < int'(rlmf_pkg::LOW_SAT)) low_sum++;
                end
                if (cr == rw - 1 && cc == wd - 1) frame_over = 1'b1;
                r.decided      = 1'b1;
                r.is_low_point = low;
                r.pixel_column = cc[rlmf_pkg::COL_W-1:0];
                r.pixel_row    = cr[rlmf_pkg::ROW_W-1:0];
            end
        end
        r.risk_total = risk_sum[rlmf_pkg::RISK_W-1:0];
        r.low_count  = low_sum[rlmf_pkg::LOW_W-1:0];
        r.frame_done = frame_over;
        return r;
    endfunction

    task automatic push_word(logic req, int h);
        stim_act_t a;
        a.kind = ACT_WORD;
        a.word.req_type = req;
        a.word.height_value = h[rlmf_pkg::PIX_W-1:0];
        a.idx = '0;
        a.val = '0;
        stim_q.push_back(a);
        words_queued++;
    endtask

    task automatic push_write(logic [rlmf_pkg::CFG_IDX_W-1:0] idx, int val);
        stim_act_t a;
        a.kind = ACT_WRITE;
        a.word = '0;
        a.idx = idx;
        a.val = val[rlmf_pkg::CFG_DATA_W-1:0];
        stim_q.push_back(a);
    endtask

    task automatic push_hold();
        stim_act_t a;
        a.kind = ACT_HOLD;
        a.word = '0;
        a.idx = '0;
        a.val = '0;
        stim_q.push_back(a);
    endtask

    // Configure a frame and stream its pixels; a whole frame also gets its flush
    // words and a few ignored words after completion, a partial one is cut short.
    task automatic push_frame(int wv, int rv, bit whole);
        int ew, er, npix, shape, plateau, h, r, c;
        ew = eff_width(wv);
        er = eff_rows(rv);
        shape = $urandom_range(0, 4);
        plateau = $urandom_range(0, 9);
        if ($urandom_range(0, 1) == 0) begin
            push_write(rlmf_pkg::CFG_IMAGE_WIDTH, wv);
            push_write(rlmf_pkg::CFG_IMAGE_ROWS, rv);
        end else begin
            push_write(rlmf_pkg::CFG_IMAGE_ROWS, rv);
            push_write(rlmf_pkg::CFG_IMAGE_WIDTH, wv);
        end
        npix = whole ? ew * er : $urandom_range(0, (ew * er < 60) ? ew * er : 60);
        for (int k = 0; k < npix; k++) begin
            r = k / ew;
            c = k % ew;
            case (shape)
                0: h = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 15)
                                                     : $urandom_range(0, 9);
                1: h = (r % 2 == 0 && c % 2 == 0) ? $urandom_range(0, 4)
                                                   : $urandom_range(5, 9);
                2: h = plateau;
                3: h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : 9;
                default: h = $urandom_range(0, 15);
            endcase
            // early flush: dropped while the image is still arriving
            if (k > 0 && $urandom_range(0, 39) == 0)
                push_word(rlmf_pkg::REQ_FLUSH, $urandom_range(0, 15));
            if ($urandom_range(0, 149) == 0) push_hold();
            push_word(rlmf_pkg::REQ_PIXEL, h);
        end
        if (whole) begin
            for (int k = 0; k <= ew; k++)
                push_word(($urandom_range(0, 5) == 0) ? rlmf_pkg::REQ_PIXEL
                                                      : rlmf_pkg::REQ_FLUSH,
                          $urandom_range(0, 15));
            repeat ($urandom_range(0, 2))
                push_word(1'($urandom_range(0, 1)), $urandom_range(0, 15));
        end
    endtask

    // driver: launch words in bursts, perform register writes only when idle
    always @(posedge aclk) begin
        logic               go_valid;
        logic               go_wr;
        rlmf_pkg::in_word_t go_data;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            cfg_wr_en  <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
            settle     = 0;
        end else begin
            if (s_valid && s_ready) decision_q.push_back(decide_pixel(s_data));
            if (s_valid || m_valid || cfg_wr_en) settle = 0;
            else if (settle < SETTLE_CYCLES) settle++;
            go_valid = s_valid && !s_ready;
            go_data  = s_data;
            go_wr    = 1'b0;
            if (!go_valid && stim_q.size() != 0) begin
                case (stim_q[0].kind)
                    ACT_WORD: begin
                        if (gap_left > 0) begin
                            gap_left--;
                        end else begin
                            go_valid = 1'b1;
                            go_data  = stim_q[0].word;
                            void'(stim_q.pop_front());
                            if (burst_left > 0) burst_left--;
                            if (burst_left == 0) begin
                                burst_left = ($urandom_range(0, 7) == 0) ? 200
                                                                         : $urandom_range(1, 16);
                                gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20)
                                                                       : $urandom_range(0, 5);
                            end
                        end
                    end
                    ACT_WRITE: begin
                        if (decision_q.size() == 0 && settle >= SETTLE_CYCLES) begin
                            go_wr = 1'b1;
                            cfg_addr  <= stim_q[0].idx;
                            cfg_wdata <= stim_q[0].val;
                            apply_setting(stim_q[0].idx, stim_q[0].val);
                            void'(stim_q.pop_front());
                        end
                    end
                    default: begin
                        if (decision_q.size() == 0 && settle >= SETTLE_CYCLES)
                            void'(stim_q.pop_front());
                    end
                endcase
            end
            s_valid   <= go_valid;
            s_data    <= go_data;
            cfg_wr_en <= go_wr;
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // monitor: compare each result word with the oldest prediction, stall on a pattern
    always @(posedge aclk) begin
        rlmf_pkg::out_word_t want;
        logic                rdy;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (decision_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("result word with nothing pending: %p", m_data);
                end else begin
                    want = decision_q.pop_front();
                    check_field("decided", 32'(want.decided), 32'(m_data.decided));
                    check_field("is_low_point", 32'(want.is_low_point),
                                32'(m_data.is_low_point));
                    check_field("pixel_column", 32'(want.pixel_column),
                                32'(m_data.pixel_column));
                    check_field("pixel_row", 32'(want.pixel_row), 32'(m_data.pixel_row));
                    check_field("risk_total", 32'(want.risk_total), 32'(m_data.risk_total));
                    check_field("low_count", 32'(want.low_count), 32'(m_data.low_count));
                    check_field("frame_done", 32'(want.frame_done), 32'(m_data.frame_done));
                end
            end
            rdy_cyc++;
            case ((rdy_cyc / 256) % 4)
                0: rdy = 1'b1;
                1: rdy = $urandom_range(0, 3) != 0;
                2: rdy = (rdy_cyc % 7) < 4;
                default: begin
                    if (rdy_hold > 0) begin
                        rdy_hold--;
                        rdy = 1'b0;
                    end else begin
                        if ($urandom_range(0, 15) == 0) rdy_hold = $urandom_range(1, 10);
                        rdy = 1'b1;
                    end
                end
            endcase
            m_ready <= rdy;
        end
    end

    // watchdog: end the run if nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) stall_run = 0;
            else stall_run++;
            if (stall_run >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        int demo[9];
        int pick, wv, rv;
        demo = '{2, 5, 0, 5, 1, 1, 0, 5, 15};
        width_reg = rlmf_pkg::WIDTH_RESET;
        rows_reg  = rlmf_pkg::ROWS_RESET;
        for (int k = 0; k < rlmf_pkg::MAX_WIDTH; k++) begin
            old_line[k] = '0;
            new_line[k] = '0;
        end
        restart_frame();

        // reset settings: two pixels and an early flush
        push_word(rlmf_pkg::REQ_PIXEL, 0);
        push_word(rlmf_pkg::REQ_PIXEL, 15);
        push_word(rlmf_pkg::REQ_FLUSH, 9);
        push_hold();
        // 3x3 frame: corner minima, an equal right neighbour, then drain
        push_write(rlmf_pkg::CFG_IMAGE_WIDTH, 3);
        push_write(rlmf_pkg::CFG_IMAGE_ROWS, 3);
        foreach (demo[k]) push_word(rlmf_pkg::REQ_PIXEL, demo[k]);
        push_word(rlmf_pkg::REQ_FLUSH, 0);
        push_word(rlmf_pkg::REQ_PIXEL, 7);
        push_word(rlmf_pkg::REQ_FLUSH, 0);
        push_word(rlmf_pkg::REQ_FLUSH, 0);
        push_word(rlmf_pkg::REQ_FLUSH, 0);
        push_word(rlmf_pkg::REQ_PIXEL, 4);
        // zero registers act as a single pixel image
        push_write(rlmf_pkg::CFG_IMAGE_WIDTH, 0);
        push_write(rlmf_pkg::CFG_IMAGE_ROWS, 0);
        push_word(rlmf_pkg::REQ_PIXEL, 6);
        push_word(rlmf_pkg::REQ_FLUSH, 0);
        push_word(rlmf_pkg::REQ_FLUSH, 0);

        push_frame(128, 1, 1'b1);
        push_frame(255, 2047, 1'b0);
        push_frame(1, 1024, 1'b0);
        while (words_queued < ITEM_BUDGET) begin
            pick = $urandom_range(0, 19);
            wv = (pick == 0) ? 0 : $urandom_range(1, 12);
            rv = (pick == 1) ? 0 : $urandom_range(1, 10);
            if (pick == 2) rv = $urandom_range(1025, 2047);
            if (pick == 3) wv = $urandom_range(129, 255);
            push_frame(wv, rv, pick > 3);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        while (stim_q.size() != 0 || s_valid || decision_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && decision_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
